// ===== hw/rtl/ntdg_pkg.sv =====
// Shared types, constants and helpers for the NoC traffic destination generator.
`default_nettype none

package ntdg_pkg;

  // Field widths fixed by the interface
  localparam int SRC_W      = 8;
  localparam int GRID_W     = 5;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Effective radix never exceeds what the grid_radix field can hold
  localparam int RADIX_W = GRID_W;
  localparam int CORES_W = 2 * RADIX_W;

  // Parameter defaults
  localparam int DEFAULT_MAX_RADIX   = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_RADIX   = 2'd1;

  // Pattern codes
  localparam logic [MODE_W-1:0] PAT_UNIFORM   = 3'd0;
  localparam logic [MODE_W-1:0] PAT_NEIGHBOUR = 3'd1;
  localparam logic [MODE_W-1:0] PAT_BITCOMP   = 3'd2;
  localparam logic [MODE_W-1:0] PAT_TRANSPOSE = 3'd3;
  localparam logic [MODE_W-1:0] PAT_TORNADO   = 3'd4;

  // Reset values
  localparam logic [MODE_W-1:0]  RESET_MODE  = PAT_UNIFORM;
  localparam logic [RADIX_W-1:0] RESET_RADIX = 5'd4;
  localparam logic [CORES_W-1:0] RESET_CORES = 10'd16;

  typedef struct packed {
    logic [SRC_W-1:0] source_core;
    logic [SRC_W-1:0] rand_value;
  } in_item_t;

  typedef struct packed {
    logic [SRC_W-1:0] dest_core;
    logic             bad_source;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [SRC_W-1:0]   src;
    logic [SRC_W-1:0]   rnd;
    logic [CORES_W-1:0] rnd_mod;
    logic [RADIX_W-1:0] x;
    logic [RADIX_W-1:0] y;
    logic               bad;
  } cls_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // v mod 3 through a reciprocal multiply: floor(v*171/512) is exact for 8-bit v
  function automatic logic [1:0] mod3(input logic [SRC_W-1:0] v);
    logic [15:0]      p;
    logic [6:0]       q;
    logic [SRC_W-1:0] r;
    p = 16'(v) * 16'd171;
    q = p[15:9];
    r = v - 8'(q) * 8'd3;
    return r[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ntdg_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with a shared hold enable.
`default_nettype none

module ntdg_div #(
  parameter int DW = ntdg_pkg::RADIX_W
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [ntdg_pkg::SRC_W-1:0] dividend,
  input  wire logic [DW-1:0]             divisor,
  output logic      [ntdg_pkg::SRC_W-1:0] quotient,
  output logic      [DW-1:0]             remainder
);

  localparam int NB = ntdg_pkg::SRC_W;

  logic [NB-1:0] dvd_r   [NB];
  logic [NB-1:0] quo_r   [NB];
  logic [DW-1:0] rem_r   [NB];
  logic [NB-1:0] dvd_nxt [NB];
  logic [NB-1:0] quo_nxt [NB];
  logic [DW-1:0] rem_nxt [NB];

  always_comb begin
    logic [NB-1:0] dvd_in;
    logic [NB-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [DW:0]   trial;
    logic          ge;
    for (int s = 0; s < NB; s++) begin
      if (s == 0) begin
        dvd_in = dividend;
        quo_in = '0;
        rem_in = '0;
      end else begin
        dvd_in = dvd_r[s-1];
        quo_in = quo_r[s-1];
        rem_in = rem_r[s-1];
      end
      trial = {rem_in, dvd_in[NB-1-s]};
      ge    = (trial >= {1'b0, divisor});
      dvd_nxt[s] = dvd_in;
      quo_nxt[s] = quo_in;
      quo_nxt[s][NB-1-s] = ge;
      if (ge) begin
        rem_nxt[s] = DW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt[s] = trial[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r <= dvd_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r[NB-1];
  assign remainder = rem_r[NB-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ntdg_front.sv =====
// Front end: accept requests, flag bad sources, split source into x/y and reduce rand mod n.
`default_nettype none

module ntdg_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ntdg_pkg::in_item_t          in_data,
  input  wire logic [ntdg_pkg::RADIX_W-1:0] radix,
  input  wire logic [ntdg_pkg::CORES_W-1:0] cores,
  input  wire ntdg_pkg::q_stat_t           q_stat,
  output logic                             push,
  output ntdg_pkg::cls_t                   push_item
);

  localparam int NB = ntdg_pkg::SRC_W;

  typedef struct packed {
    logic [ntdg_pkg::SRC_W-1:0] src;
    logic [ntdg_pkg::SRC_W-1:0] rnd;
    logic                       bad;
  } side_t;

  logic                       en;
  logic [NB-1:0]              vld_r;
  logic [NB-1:0]              vld_nxt;
  side_t                      side_r   [NB];
  side_t                      side_nxt [NB];
  logic [ntdg_pkg::SRC_W-1:0] xy_quo;
  logic [ntdg_pkg::RADIX_W-1:0] xy_rem;
  logic [ntdg_pkg::SRC_W-1:0] rm_quo;
  logic [ntdg_pkg::CORES_W-1:0] rm_rem;

  // Hold the whole pipe while the queue is full
  assign en       = !q_stat.full;
  assign in_ready = en;

  always_comb begin
    vld_nxt = {vld_r[NB-2:0], in_valid};
    side_nxt[0].src = in_data.source_core;
    side_nxt[0].rnd = in_data.rand_value;
    side_nxt[0].bad = (ntdg_pkg::CORES_W'(in_data.source_core) >= cores);
    for (int s = 1; s < NB; s++) begin
      side_nxt[s] = side_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
    end
  end

  ntdg_div #(.DW(ntdg_pkg::RADIX_W)) u_div_xy (
    .clk       (clk),
    .en        (en),
    .dividend  (in_data.source_core),
    .divisor   (radix),
    .quotient  (xy_quo),
    .remainder (xy_rem)
  );

  ntdg_div #(.DW(ntdg_pkg::CORES_W)) u_div_rnd (
    .clk       (clk),
    .en        (en),
    .dividend  (in_data.rand_value),
    .divisor   (cores),
    .quotient  (rm_quo),
    .remainder (rm_rem)
  );

  assign push = vld_r[NB-1] && en;

  // y only matters for a source inside the grid, where it is below the radix
  always_comb begin
    push_item.src     = side_r[NB-1].src;
    push_item.rnd     = side_r[NB-1].rnd;
    push_item.rnd_mod = rm_rem;
    push_item.x       = xy_rem;
    push_item.y       = xy_quo[ntdg_pkg::RADIX_W-1:0];
    push_item.bad     = side_r[NB-1].bad | (|rm_quo & 1'b0);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ntdg_queue.sv =====
// Small FIFO of classified items between the front and back ends.
`default_nettype none

module ntdg_queue #(
  parameter int DEPTH = ntdg_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ntdg_pkg::cls_t    push_item,
  input  wire logic              pop,
  output ntdg_pkg::q_stat_t      q_stat,
  output ntdg_pkg::cls_t         head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ntdg_pkg::cls_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  assign head_item    = mem_r[rd_r];
  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == FULL_CNT);

endmodule

`default_nettype wire

// ===== hw/rtl/ntdg_back.sv =====
// Back end: apply the traffic pattern to a classified item and hold the result.
`default_nettype none

module ntdg_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ntdg_pkg::q_stat_t           q_stat,
  input  wire ntdg_pkg::cls_t              head_item,
  output logic                             pop,
  input  wire logic [ntdg_pkg::MODE_W-1:0]  mode,
  input  wire logic [ntdg_pkg::RADIX_W-1:0] radix,
  input  wire logic [ntdg_pkg::CORES_W-1:0] cores,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ntdg_pkg::out_item_t              out_data
);

  localparam int RW = ntdg_pkg::RADIX_W;
  localparam int NW = ntdg_pkg::CORES_W;

  logic                    out_valid_r, out_valid_nxt;
  ntdg_pkg::out_item_t     out_data_r, out_data_nxt;
  logic [RW-1:0]           last, x, y, nb_x, nb_y, gx, gy;
  logic                    x0, xl, y0, yl;
  logic [1:0]              sel3;
  logic [RW:0]             torn;
  logic [NW-1:0]           prod;
  logic [NW:0]             usum, grid_sum;
  logic [ntdg_pkg::SRC_W-1:0] dest;

  assign pop = q_stat.valid && (!out_valid_r || out_ready);

  // Nearest neighbour: corners pick from 2, edges from 3, interior from 4
  always_comb begin
    last = radix - 1'b1;
    x    = head_item.x;
    y    = head_item.y;
    x0   = (x == '0);
    xl   = (x == last);
    y0   = (y == '0);
    yl   = (y == last);
    sel3 = ntdg_pkg::mod3(head_item.rnd);
    nb_x = x;
    nb_y = y;
    if (x0 && y0) begin
      if (!head_item.rnd[0]) nb_x = x + 1'b1;
      else                   nb_y = y + 1'b1;
    end else if (xl && y0) begin
      if (!head_item.rnd[0]) nb_x = x - 1'b1;
      else                   nb_y = y + 1'b1;
    end else if (x0 && yl) begin
      if (!head_item.rnd[0]) nb_y = y - 1'b1;
      else                   nb_x = x + 1'b1;
    end else if (xl && yl) begin
      if (!head_item.rnd[0]) nb_y = y - 1'b1;
      else                   nb_x = x - 1'b1;
    end else if (x0) begin
      if (sel3 == 2'd0)      nb_x = x + 1'b1;
      else if (sel3 == 2'd1) nb_y = y + 1'b1;
      else                   nb_y = y - 1'b1;
    end else if (y0) begin
      if (sel3 == 2'd0)      nb_x = x - 1'b1;
      else if (sel3 == 2'd1) nb_x = x + 1'b1;
      else                   nb_y = y + 1'b1;
    end else if (xl) begin
      if (sel3 == 2'd0)      nb_x = x - 1'b1;
      else if (sel3 == 2'd1) nb_y = y + 1'b1;
      else                   nb_y = y - 1'b1;
    end else if (yl) begin
      if (sel3 == 2'd0)      nb_x = x - 1'b1;
      else if (sel3 == 2'd1) nb_x = x + 1'b1;
      else                   nb_y = y - 1'b1;
    end else begin
      if (head_item.rnd[1:0] == 2'd0)      nb_x = x - 1'b1;
      else if (head_item.rnd[1:0] == 2'd1) nb_x = x + 1'b1;
      else if (head_item.rnd[1:0] == 2'd2) nb_y = y + 1'b1;
      else                                 nb_y = y - 1'b1;
    end
  end

  always_comb begin
    // Tornado shifts x by k/2-1 and clamps at the right edge
    torn = {1'b0, x} + {2'b0, radix[RW-1:1]} - 1'b1;
    gx   = x;
    gy   = y;
    case (mode)
      ntdg_pkg::PAT_NEIGHBOUR: begin
        gx = nb_x;
        gy = nb_y;
      end
      ntdg_pkg::PAT_BITCOMP: begin
        gx = last - x;
        gy = last - y;
      end
      ntdg_pkg::PAT_TRANSPOSE: begin
        gx = y;
        gy = x;
      end
      ntdg_pkg::PAT_TORNADO: begin
        gx = (torn >= {1'b0, radix}) ? last : torn[RW-1:0];
      end
      default: begin
        gx = x;
        gy = y;
      end
    endcase
    prod     = NW'(gy) * NW'(radix);
    grid_sum = {1'b0, prod} + (NW+1)'(gx);
    // Uniform: both terms are below n, so one subtract wraps the sum
    usum = (NW+1)'(head_item.src) + {1'b0, head_item.rnd_mod};
    if (usum >= {1'b0, cores}) begin
      usum = usum - {1'b0, cores};
    end
    case (mode)
      ntdg_pkg::PAT_UNIFORM:   dest = usum[ntdg_pkg::SRC_W-1:0];
      ntdg_pkg::PAT_NEIGHBOUR,
      ntdg_pkg::PAT_BITCOMP,
      ntdg_pkg::PAT_TRANSPOSE,
      ntdg_pkg::PAT_TORNADO:   dest = grid_sum[ntdg_pkg::SRC_W-1:0];
      default:                 dest = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.bad_source = head_item.bad;
      out_data_nxt.dest_core  = head_item.bad ? '0 : dest;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/noc_traffic_destination_gen.sv =====
// Top level of the NoC synthetic traffic destination generator.
//
// Usage: each transfer on the in_ channel carries a source core index and a
// random value; the block returns one transfer on the out_ channel with the
// destination core picked by the configured pattern (uniform, nearest
// neighbour, bit complement, transpose, tornado) on a k by k mesh, plus a
// bad_source flag for a source at or beyond k*k (destination then 0).
// Configuration: cfg_ channel, index 0 pattern_mode, index 1 grid_radix
// (clamped to 2..MAX_RADIX); cfg_ready is always high. Write it only idle.
// Throughput: one request per cycle, sustained while the queue is not full.
// Path: the front end is an 8-stage pipelined divider (one quotient bit per
// stage) splitting the source into x/y and reducing rand mod k*k; items then
// pass through the queue and the pattern logic into the output register.
// Stall: while out_ready is low the queue fills; once it is full the front
// pipeline holds and in_ready drops. Results are never dropped.
// Reset: synchronous active-low rst_n clears the pipeline, queue and output
// valid and restores pattern_mode 0 and grid_radix 4.
`default_nettype none

module noc_traffic_destination_gen #(
  parameter int MAX_RADIX   = ntdg_pkg::DEFAULT_MAX_RADIX,
  parameter int QUEUE_DEPTH = ntdg_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ntdg_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ntdg_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ntdg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ntdg_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [ntdg_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [ntdg_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [ntdg_pkg::CORES_W-1:0] cores_r, cores_nxt;
  logic [ntdg_pkg::GRID_W-1:0]  grid_wr;
  ntdg_pkg::q_stat_t            q_stat;
  ntdg_pkg::cls_t               push_item;
  ntdg_pkg::cls_t               head_item;
  logic                         push;
  logic                         pop;

  // Configuration: always ready, registers take effect on the transfer
  assign cfg_ready = 1'b1;
  assign grid_wr   = cfg_data[ntdg_pkg::GRID_W-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    radix_nxt = radix_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntdg_pkg::REG_PATTERN_MODE: begin
          mode_nxt = cfg_data[ntdg_pkg::MODE_W-1:0];
        end
        ntdg_pkg::REG_GRID_RADIX: begin
          // Clamp the radix once here so downstream logic sees only legal k
          if (grid_wr < ntdg_pkg::GRID_W'(2)) begin
            radix_nxt = ntdg_pkg::RADIX_W'(2);
          end else if (int'(grid_wr) > MAX_RADIX) begin
            radix_nxt = ntdg_pkg::RADIX_W'(MAX_RADIX);
          end else begin
            radix_nxt = grid_wr;
          end
        end
        default: begin
          mode_nxt  = mode_r;
          radix_nxt = radix_r;
        end
      endcase
    end
  end

  // Core count is loaded together with the radix
  assign cores_nxt = ntdg_pkg::CORES_W'(radix_nxt) * ntdg_pkg::CORES_W'(radix_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ntdg_pkg::RESET_MODE;
      radix_r <= ntdg_pkg::RESET_RADIX;
      cores_r <= ntdg_pkg::RESET_CORES;
    end else begin
      mode_r  <= mode_nxt;
      radix_r <= radix_nxt;
      cores_r <= cores_nxt;
    end
  end

  ntdg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .radix     (radix_r),
    .cores     (cores_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  ntdg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_stat    (q_stat),
    .head_item (head_item)
  );

  ntdg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .mode      (mode_r),
    .radix     (radix_r),
    .cores     (cores_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Effective radix always stays inside the legal range
  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r >= ntdg_pkg::RADIX_W'(2)) && (int'(radix_r) <= MAX_RADIX))
    else $error("effective radix out of range");

  // Core count always matches the current radix
  a_cores_track: assert property (@(posedge clk) disable iff (!rst_n)
    cores_r == ntdg_pkg::CORES_W'(radix_r) * ntdg_pkg::CORES_W'(radix_r))
    else $error("core count does not match radix");

  // A good source always lands inside the grid
  a_dest_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.bad_source) |->
      (ntdg_pkg::CORES_W'(out_data.dest_core) < cores_r))
    else $error("destination outside the grid");

  // A bad source always reports destination zero
  a_bad_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_source) |-> (out_data.dest_core == '0))
    else $error("bad source with nonzero destination");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the NoC traffic destination generator: random and directed requests.
module tb;
  import ntdg_pkg::*;

  localparam int MAX_RADIX   = DEFAULT_MAX_RADIX;
  localparam int RAND_REQS   = 1850;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_TAIL  = 20;
  localparam int MAX_IDLE    = 19;

  // Indexes that map to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  noc_traffic_destination_gen uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the two configuration registers, updated on each cfg transfer
  logic [MODE_W-1:0] cur_mode  = RESET_MODE;
  logic [GRID_W-1:0] cur_radix = RESET_RADIX;

  in_item_t  req_pending[$];   // requests not yet presented to the block
  out_item_t dest_expect[$];   // predicted destinations, oldest first

  int reqs_issued   = 0;
  int dests_checked = 0;
  int dest_errors   = 0;
  int bad_seen      = 0;
  int cfg_writes    = 0;
  int cycle_count   = 0;

  // Handshake flags from the last rising edge, read by the falling-edge drivers
  bit in_xfer  = 1'b0;
  bit out_xfer = 1'b0;
  int in_wait  = 0;
  int out_wait = 0;
  int in_max_gap    = 0;
  int out_max_stall = 0;

  // Destination for one request under the given pattern and radix
  function automatic out_item_t route_dest(input in_item_t req,
                                           input logic [MODE_W-1:0] mode,
                                           input logic [GRID_W-1:0] radix);
    int unsigned k, last, cores, src, rnd, x, y, nx, dest;
    out_item_t res;
    k = radix;
    if (k < 2) k = 2;
    if (k > MAX_RADIX) k = MAX_RADIX;
    last  = k - 1;
    cores = k * k;
    src   = req.source_core;
    rnd   = req.rand_value;
    dest  = 0;
    res.bad_source = (src >= cores);
    if (!res.bad_source) begin
      x = src % k;
      y = src / k;
      case (mode)
        PAT_UNIFORM:   dest = (src + rnd) % cores;
        PAT_NEIGHBOUR: begin
          // corners offer two moves, edges three, interior four
          if (src == 0)                dest = (rnd % 2 == 0) ? 1 : k;
          else if (src == last)        dest = (rnd % 2 == 0) ? k - 2 : 2 * k - 1;
          else if (src == k * last)    dest = (rnd % 2 == 0) ? k * (k - 2) : k * last + 1;
          else if (src == cores - 1)   dest = (rnd % 2 == 0) ? k * last - 1 : cores - 2;
          else begin
            if (x == 0) begin
              case (rnd % 3)
                0:       x = x + 1;
                1:       y = y + 1;
                default: y = y - 1;
              endcase
            end else if (y == 0) begin
              case (rnd % 3)
                0:       x = x - 1;
                1:       x = x + 1;
                default: y = y + 1;
              endcase
            end else if (x == last) begin
              case (rnd % 3)
                0:       x = x - 1;
                1:       y = y + 1;
                default: y = y - 1;
              endcase
            end else if (y == last) begin
              case (rnd % 3)
                0:       x = x - 1;
                1:       x = x + 1;
                default: y = y - 1;
              endcase
            end else begin
              case (rnd % 4)
                0:       x = x - 1;
                1:       x = x + 1;
                2:       y = y + 1;
                default: y = y - 1;
              endcase
            end
            dest = x + y * k;
          end
        end
        PAT_BITCOMP:   dest = (last - x) + (last - y) * k;
        PAT_TRANSPOSE: dest = y + x * k;
        PAT_TORNADO: begin
          // clamp at the right edge, no wraparound
          nx = x + k / 2 - 1;
          if (nx >= k) nx = last;
          dest = nx + y * k;
        end
        default:       dest = 0;
      endcase
    end
    res.dest_core = dest[SRC_W-1:0];
    return res;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // Request driver: hold a presented request until its transfer, then idle or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (req_pending.size() > 0) begin
        in_data  <= req_pending.pop_front();
        in_valid <= 1'b1;
        in_wait = $urandom_range(0, in_max_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure: draw a stall after every result transfer
  always @(negedge clk) begin
    if (out_xfer) out_wait = $urandom_range(0, out_max_stall);
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each request transfer, check each result transfer
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    in_xfer  = rst_n && in_valid && in_ready;
    out_xfer = rst_n && out_valid && out_ready;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PATTERN_MODE) cur_mode = cfg_data[MODE_W-1:0];
      else if (cfg_index == REG_GRID_RADIX) cur_radix = cfg_data[GRID_W-1:0];
    end
    if (in_xfer) dest_expect = {dest_expect, route_dest(in_data, cur_mode, cur_radix)};
    if (out_xfer) begin
      if (dest_expect.size() == 0) begin
        $error("unexpected result: dest_core %0d bad_source %0b",
               out_data.dest_core, out_data.bad_source);
        dest_errors++;
      end else begin
        want = dest_expect.pop_front();
        dests_checked++;
        if (want.bad_source) bad_seen++;
        if (out_data.dest_core !== want.dest_core) begin
          $error("dest_core: expected %0d, got %0d", want.dest_core, out_data.dest_core);
          dest_errors++;
        end
        if (out_data.bad_source !== want.bad_source) begin
          $error("bad_source: expected %0b, got %0b", want.bad_source, out_data.bad_source);
          dest_errors++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, reqs_issued - dests_checked);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_req(input int src, input int rnd);
    in_item_t req;
    req.source_core = src[SRC_W-1:0];
    req.rand_value  = rnd[SRC_W-1:0];
    req_pending = {req_pending, req};
    reqs_issued++;
  endtask

  // Wait until every issued request has produced its checked result
  task automatic drain();
    while (dests_checked != reqs_issued) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Stimulus: directed corner cases, then random phases under changing configuration
  initial begin
    int rand_reqs;
    int phase_len;
    int k;
    int cores;
    int src;
    int rnd;
    logic [MODE_W-1:0] mode_pick;
    logic [GRID_W-1:0] radix_pick;

    rand_reqs = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: uniform on a 4x4 mesh; first and last core, sources off the grid,
    // random value far above the core count
    push_req(0, 0);
    push_req(15, 255);
    push_req(16, 0);
    push_req(255, 255);
    drain();

    // Neighbour on the smallest mesh (radix below two clamps to two): every core is a corner
    write_reg(REG_PATTERN_MODE, {5'b0, PAT_NEIGHBOUR});
    write_reg(REG_GRID_RADIX, 8'd0);
    push_req(0, 0);
    push_req(1, 1);
    push_req(2, 254);
    push_req(3, 3);
    drain();

    // Bit complement with an oversize radix, clamped to the maximum
    write_reg(REG_PATTERN_MODE, {5'b0, PAT_BITCOMP});
    write_reg(REG_GRID_RADIX, 8'd31);
    push_req(0, 0);
    push_req(255, 128);
    drain();

    // Transpose on a 5x5 mesh, last core and first core off the grid
    write_reg(REG_PATTERN_MODE, {5'b0, PAT_TRANSPOSE});
    write_reg(REG_GRID_RADIX, 8'd5);
    push_req(7, 0);
    push_req(24, 200);
    push_req(25, 0);
    drain();

    // Tornado with radix one (clamped to two)
    write_reg(REG_PATTERN_MODE, {5'b0, PAT_TORNADO});
    write_reg(REG_GRID_RADIX, 8'd1);
    write_reg(REG_SPARE_LO, 8'hFF);
    push_req(1, 0);
    push_req(2, 0);
    drain();

    // Unused pattern codes, upper data bits set on both registers
    write_reg(REG_PATTERN_MODE, 8'hFD);
    write_reg(REG_GRID_RADIX, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    push_req(17, 3);
    push_req(255, 0);
    drain();
    write_reg(REG_PATTERN_MODE, {5'b0, {MODE_W{1'b1}}});
    push_req(100, 77);
    drain();

    // Random phases: mostly legal patterns and radices, with idling varied per phase
    while (rand_reqs < RAND_REQS) begin
      if ($urandom_range(0, 9) == 0)
        mode_pick = MODE_W'($urandom_range(PAT_TORNADO + 1, {MODE_W{1'b1}}));
      else mode_pick = MODE_W'($urandom_range(PAT_UNIFORM, PAT_TORNADO));
      if ($urandom_range(0, 4) == 0) radix_pick = GRID_W'($urandom_range(0, {GRID_W{1'b1}}));
      else radix_pick = GRID_W'($urandom_range(2, MAX_RADIX));
      write_reg(REG_PATTERN_MODE, {5'($urandom), mode_pick});
      write_reg(REG_GRID_RADIX, {3'($urandom), radix_pick});
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));

      k = radix_pick;
      if (k < 2) k = 2;
      if (k > MAX_RADIX) k = MAX_RADIX;
      cores = k * k;
      in_max_gap    = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;
      out_max_stall = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;

      phase_len = $urandom_range(60, 140);
      repeat (phase_len) begin
        src = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cores - 1);
        rnd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cores - 1);
        push_req(src, rnd);
        rand_reqs++;
      end
      drain();
    end

    // Catch any stray result after the last expected one
    repeat (DRAIN_TAIL) @(posedge clk);
    if (dest_expect.size() != 0) begin
      $error("%0d expected results never arrived", dest_expect.size());
      dest_errors++;
    end

    $display("Checked %0d destinations (%0d off-grid sources) over %0d register writes.",
             dests_checked, bad_seen, cfg_writes);
    $display("All five patterns, unused codes and clamped radices ran with random idling.");
    if (dest_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ntdg_pkg.sv
hw/rtl/ntdg_div.sv
hw/rtl/ntdg_front.sv
hw/rtl/ntdg_queue.sv
hw/rtl/ntdg_back.sv
hw/rtl/noc_traffic_destination_gen.sv
sim/tb.sv
